// ===== rtl/bhte_pkg.sv =====
// shared types and constants for the bucketed hash table engine
`default_nettype none

package bhte_pkg;

	// fixed field widths of the transaction channels
	localparam int KEY_W       = 31;
	localparam int PORT_PAY_W  = 64;
	localparam int BLKNUM_W    = 8;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;

	// bucket reduction: padded key taken one byte a step, msb first
	localparam int HASH_IN_W   = 32;
	localparam int HASH_DIG_W  = 8;
	localparam int HASH_STEPS  = HASH_IN_W / HASH_DIG_W;
	localparam int HASH_CNT_W  = $clog2(HASH_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 2'd0,
		OP_FIND_KEY   = 2'd1,
		OP_FIND_BLOCK = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_FOUND     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_BASE,
		S_READ,
		S_CHECK,
		S_PAY,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/bhte_req_if.sv =====
// request channel: operation, key, payload and block number
`default_nettype none

interface bhte_req_if;
	import bhte_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [KEY_W-1:0]      key;
	logic [PORT_PAY_W-1:0] payload;
	logic [BLKNUM_W-1:0]   block_number;

	modport source (
		output valid, operation, key, payload, block_number,
		input  ready
	);

	modport sink (
		input  valid, operation, key, payload, block_number,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bhte_rsp_if.sv =====
// response channel: status, block and the found record
`default_nettype none

interface bhte_rsp_if;
	import bhte_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [BLKNUM_W-1:0]   result_block;
	logic [KEY_W-1:0]      found_key;
	logic [PORT_PAY_W-1:0] found_payload;

	modport source (
		output valid, status, result_block, found_key, found_payload,
		input  ready
	);

	modport sink (
		input  valid, status, result_block, found_key, found_payload,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bucketed_hash_table_engine_top.sv =====
// bucketed hash table engine: static bucket store with insert and lookup
//
// One request on req (insert, find by key, find in a given block) gives one
// response on rsp. A key's bucket is key mod NUM_BUCKETS; each bucket owns
// BLOCKS_PER_BUCKET blocks of SLOTS_PER_BLOCK slots, a key of zero marks an
// empty slot. A whole block of keys is one memory row and is compared at
// once by one bank of slot comparators that the sequencer reuses.
// Steps from request to response (defaults): insert and find by key run the
// bucket reduction, the block base, a read and a check per block visited
// (1 to 4), a payload read on a find hit and the response load. Find in
// block reads and checks the given block, reads the payload on a hit and
// loads the response; a rejected request goes straight to the response.
// One request is in flight at a time and the next is taken in the cycle
// after the response is loaded; the pace is set by the bucket reduction
// and the one read port of the key memory.
// After reset the key memory is cleared one row a cycle, all TOTAL_BLOCKS
// rows (256 by default), and req.ready stays low meanwhile.
// The response sits in an output register: a new request is accepted while
// rsp is stalled, but its response waits until the held one is taken.
`default_nettype none

module bucketed_hash_table_engine_top #(
	parameter int NUM_BUCKETS       = 64,
	parameter int BLOCKS_PER_BUCKET = 4,
	parameter int SLOTS_PER_BLOCK   = 8,
	parameter int PAYLOAD_WIDTH     = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	bhte_req_if.sink   req,
	bhte_rsp_if.source rsp
);
	import bhte_pkg::*;

	localparam int TOTAL_BLOCKS = NUM_BUCKETS * BLOCKS_PER_BUCKET;
	localparam int TOTAL_SLOTS  = TOTAL_BLOCKS * SLOTS_PER_BLOCK;
	localparam int BLK_W  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
	localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int LANE_W = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CNT_W  = $clog2(BLOCKS_PER_BUCKET + 1);
	localparam int MUL_W  = BLK_W + CNT_W;
	localparam int ROW_W  = SLOTS_PER_BLOCK * KEY_W;
	localparam int RED_W  = BKT_W + HASH_DIG_W;

	// memories
	logic [ROW_W-1:0]         key_mem [TOTAL_BLOCKS];
	logic [PAYLOAD_WIDTH-1:0] pay_mem [TOTAL_SLOTS];
	logic [ROW_W-1:0]         row_rd_q;
	logic [PAYLOAD_WIDTH-1:0] pay_rd_q;

	// control and working registers
	state_t                   state_q, state_d;
	logic [BLK_W-1:0]         clr_q;
	op_t                      op_q;
	logic [KEY_W-1:0]         key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_in_q;
	logic [HASH_IN_W-1:0]     hkey_q;
	logic [HASH_CNT_W-1:0]    dig_q;
	logic [BKT_W-1:0]         rem_q;
	logic [BLK_W-1:0]         blk_q;
	logic [CNT_W-1:0]         bcnt_q;
	status_t                  res_status_q;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [BLKNUM_W-1:0]      out_blk_q;
	logic [KEY_W-1:0]         out_key_q;
	logic [PORT_PAY_W-1:0]    out_pay_q;

	// combinational signals
	logic                     is_insert;
	logic                     blk_in_range;
	logic                     out_free;
	logic [RED_W-1:0]         red_t;
	logic [BKT_W-1:0]         red_next;
	logic [SLOTS_PER_BLOCK-1:0] lane_eq, lane_emp, lane_stop;
	logic [LANE_W-1:0]        first_lane;
	logic                     any_stop;
	logic                     first_is_eq;
	logic                     key_we, pay_we, pay_re, key_re;
	logic [BLK_W-1:0]         key_waddr;
	logic [ROW_W-1:0]         key_wdata;
	logic [SLOT_W-1:0]        slot_addr;

	assign is_insert    = (op_q == OP_INSERT);
	assign blk_in_range = (32'(req.block_number) < 32'(TOTAL_BLOCKS));
	assign out_free     = !out_valid_q || rsp.ready;

	// bucket reduction: one byte of the key folded into the remainder per step
	always_comb begin
		red_t = {rem_q, hkey_q[HASH_IN_W-1 -: HASH_DIG_W]};
		for (int i = HASH_DIG_W - 1; i >= 0; i--) begin
			if (red_t >= (RED_W'(NUM_BUCKETS) << i)) begin
				red_t = red_t - (RED_W'(NUM_BUCKETS) << i);
			end
		end
		red_next = BKT_W'(red_t);
	end

	// slot comparators over the row just read
	always_comb begin
		for (int s = 0; s < SLOTS_PER_BLOCK; s++) begin
			lane_eq[s]  = (row_rd_q[s*KEY_W +: KEY_W] == key_q);
			lane_emp[s] = (row_rd_q[s*KEY_W +: KEY_W] == '0);
		end
		lane_stop = is_insert ? (lane_eq | lane_emp) : lane_eq;
	end

	// first slot that ends the walk
	always_comb begin
		first_lane = '0;
		for (int s = SLOTS_PER_BLOCK - 1; s >= 0; s--) begin
			if (lane_stop[s]) begin
				first_lane = LANE_W'(s);
			end
		end
		any_stop    = |lane_stop;
		first_is_eq = lane_eq[first_lane];
	end

	// memory port control
	always_comb begin
		slot_addr = SLOT_W'(SLOT_W'(blk_q) * SLOT_W'(SLOTS_PER_BLOCK)) + SLOT_W'(first_lane);
		key_re    = (state_q == S_READ);
		pay_we    = (state_q == S_CHECK) && is_insert && any_stop && !first_is_eq;
		pay_re    = (state_q == S_CHECK) && !is_insert && any_stop;
		key_we    = (state_q == S_CLEAR) || pay_we;
		key_waddr = (state_q == S_CLEAR) ? clr_q : blk_q;
		key_wdata = '0;
		if (state_q != S_CLEAR) begin
			key_wdata = row_rd_q;
			key_wdata[first_lane*KEY_W +: KEY_W] = key_q;
		end
	end

	// key memory: one block row per entry
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		if (key_re) begin
			row_rd_q <= key_mem[blk_q];
		end
	end

	// payload memory: one slot per entry
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[slot_addr] <= pay_in_q;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[slot_addr];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == BLK_W'(TOTAL_BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					unique case (op_t'(req.operation))
						OP_INSERT:     state_d = S_HASH;
						OP_FIND_KEY:   state_d = (req.key != '0) ? S_HASH : S_RESP;
						OP_FIND_BLOCK: begin
							state_d = (req.key != '0 && blk_in_range) ? S_READ : S_RESP;
						end
						default:       state_d = S_RESP;
					endcase
				end
			end
			S_HASH: begin
				if (dig_q == HASH_CNT_W'(HASH_STEPS - 1)) begin
					state_d = S_BASE;
				end
			end
			S_BASE:  state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (any_stop) begin
					state_d = is_insert ? S_RESP : S_PAY;
				end else if (bcnt_q == CNT_W'(1)) begin
					state_d = S_RESP;
				end else begin
					state_d = S_READ;
				end
			end
			S_PAY:   state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// clearing pass counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BLK_W'(1);
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q         <= op_t'(req.operation);
					key_q        <= req.key;
					pay_in_q     <= PAYLOAD_WIDTH'(req.payload);
					hkey_q       <= HASH_IN_W'(req.key);
					dig_q        <= '0;
					rem_q        <= '0;
					blk_q        <= BLK_W'(req.block_number);
					bcnt_q       <= CNT_W'(1);
					res_status_q <= STAT_NOT_FOUND;
				end
			end
			S_HASH: begin
				hkey_q <= hkey_q << HASH_DIG_W;
				rem_q  <= red_next;
				dig_q  <= dig_q + HASH_CNT_W'(1);
			end
			S_BASE: begin
				blk_q  <= BLK_W'(MUL_W'(rem_q) * MUL_W'(BLOCKS_PER_BUCKET));
				bcnt_q <= CNT_W'(BLOCKS_PER_BUCKET);
			end
			S_CHECK: begin
				if (any_stop) begin
					if (is_insert) begin
						res_status_q <= first_is_eq ? STAT_DUPLICATE : STAT_INSERTED;
					end else begin
						res_status_q <= STAT_FOUND;
					end
				end else if (bcnt_q == CNT_W'(1)) begin
					res_status_q <= is_insert ? STAT_FULL : STAT_NOT_FOUND;
				end else begin
					blk_q  <= blk_q + BLK_W'(1);
					bcnt_q <= bcnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// response register load
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_blk_q    <= (res_status_q == STAT_INSERTED || res_status_q == STAT_FOUND)
			                ? BLKNUM_W'(blk_q) : '0;
			out_key_q    <= (res_status_q == STAT_FOUND) ? key_q : '0;
			out_pay_q    <= (res_status_q == STAT_FOUND) ? PORT_PAY_W'(pay_rd_q) : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_block  = out_blk_q;
	assign rsp.found_key     = out_key_q;
	assign rsp.found_payload = out_pay_q;

	// checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !key_we)
		else $error("key memory written while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start");

	a_miss_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_FOUND) |->
		(rsp.found_key == '0 && rsp.found_payload == '0))
		else $error("record fields set on a response without a hit");

	a_block_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (bcnt_q != '0))
		else $error("block walk ran past the bucket");

	a_key_pay_together: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (pay_we == key_we))
		else $error("key and payload writes out of step");

endmodule

`default_nettype wire
